// ----- hw/rtl/spd_pkg.sv -----
package spd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned PaddrW = 3;

  localparam logic [PosW-1:0]  FrameBytes = PosW'(15);
  localparam logic [ByteW-1:0] StartMark  = 8'h0E;
  localparam logic [ByteW-1:0] EndMark    = 8'hFE;

  // frame byte positions
  localparam logic [PosW-1:0] PosStart     = PosW'(0);
  localparam logic [PosW-1:0] PosLength    = PosW'(1);
  localparam logic [PosW-1:0] PosId        = PosW'(2);
  localparam logic [PosW-1:0] PosLocation  = PosW'(3);
  localparam logic [PosW-1:0] PosStampLo   = PosW'(4);
  localparam logic [PosW-1:0] PosStampHi   = PosW'(7);
  localparam logic [PosW-1:0] PosLuxLo     = PosW'(8);
  localparam logic [PosW-1:0] PosLuxHi     = PosW'(11);
  localparam logic [PosW-1:0] PosCondition = PosW'(12);
  localparam logic [PosW-1:0] PosChecksum  = PosW'(13);
  localparam logic [PosW-1:0] PosEnd       = PosW'(14);

  // register index, taken from paddr[2]
  localparam logic RegTimeLimit = 1'b0;
  localparam logic [WordW-1:0] TimeLimitReset = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    StatOk       = 3'd0,
    StatShort    = 3'd1,
    StatMarker   = 3'd2,
    StatChecksum = 3'd3,
    StatFuture   = 3'd4
  } status_e;

  typedef struct packed {
    status_e          status;
    logic [ByteW-1:0] sensor_id;
    logic [ByteW-1:0] location;
    logic [WordW-1:0] time_stamp;
    logic [WordW-1:0] lux_bits;
    logic [ByteW-1:0] light_condition;
  } result_t;

endpackage

// ----- hw/rtl/spd_ifs.sv -----
interface spd_in_if;
  logic                      valid;
  logic                      ready;
  logic [spd_pkg::ByteW-1:0] rx_byte;
  logic                      line_end;

  modport source (output valid, output rx_byte, output line_end, input ready);
  modport sink   (input valid, input rx_byte, input line_end, output ready);
endinterface

interface spd_out_if;
  logic                      valid;
  logic                      ready;
  spd_pkg::status_e          status;
  logic [spd_pkg::ByteW-1:0] sensor_id;
  logic [spd_pkg::ByteW-1:0] location;
  logic [spd_pkg::WordW-1:0] time_stamp;
  logic [spd_pkg::WordW-1:0] lux_bits;
  logic [spd_pkg::ByteW-1:0] light_condition;

  modport source (output valid, output status, output sensor_id, output location,
                  output time_stamp, output lux_bits, output light_condition,
                  input ready);
  modport sink   (input valid, input status, input sensor_id, input location,
                  input time_stamp, input lux_bits, input light_condition,
                  output ready);
endinterface

// ----- hw/rtl/spd_frame_parse.sv -----
module spd_frame_parse (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      take_i,
  input  logic [spd_pkg::ByteW-1:0] rx_byte_i,
  input  logic                      line_end_i,
  input  logic [spd_pkg::WordW-1:0] time_limit_i,
  output spd_pkg::result_t          result_o
);

  logic [spd_pkg::PosW-1:0]  pos_q, pos_d;
  logic [spd_pkg::ByteW-1:0] sum_q, sum_d;
  logic                      start_ok_q, start_ok_d;
  logic                      end_ok_q, end_ok_d;
  logic [spd_pkg::ByteW-1:0] id_q, id_d;
  logic [spd_pkg::ByteW-1:0] loc_q, loc_d;
  logic [spd_pkg::WordW-1:0] stamp_q, stamp_d;
  logic [spd_pkg::WordW-1:0] lux_q, lux_d;
  logic [spd_pkg::ByteW-1:0] cond_q, cond_d;
  spd_pkg::status_e          status;

  // line state including the current word
  always_comb begin
    pos_d      = pos_q;
    sum_d      = sum_q;
    start_ok_d = start_ok_q;
    end_ok_d   = end_ok_q;
    id_d       = id_q;
    loc_d      = loc_q;
    stamp_d    = stamp_q;
    lux_d      = lux_q;
    cond_d     = cond_q;
    if (pos_q != spd_pkg::FrameBytes) begin
      pos_d = pos_q + spd_pkg::PosW'(1);
      if (pos_q >= spd_pkg::PosLength && pos_q <= spd_pkg::PosChecksum) begin
        sum_d = sum_q + rx_byte_i;
      end
      case (pos_q) inside
        spd_pkg::PosStart:     start_ok_d = (rx_byte_i == spd_pkg::StartMark);
        spd_pkg::PosId:        id_d = rx_byte_i;
        spd_pkg::PosLocation:  loc_d = rx_byte_i;
        [spd_pkg::PosStampLo:spd_pkg::PosStampHi]:
          stamp_d = {stamp_q[spd_pkg::WordW-spd_pkg::ByteW-1:0], rx_byte_i};
        [spd_pkg::PosLuxLo:spd_pkg::PosLuxHi]:
          lux_d = {lux_q[spd_pkg::WordW-spd_pkg::ByteW-1:0], rx_byte_i};
        spd_pkg::PosCondition: cond_d = rx_byte_i;
        spd_pkg::PosEnd:       end_ok_d = (rx_byte_i == spd_pkg::EndMark);
        default: ;
      endcase
    end
  end

  // checks in precedence order
  always_comb begin
    if (pos_d != spd_pkg::FrameBytes) begin
      status = spd_pkg::StatShort;
    end else if (!(start_ok_d && end_ok_d)) begin
      status = spd_pkg::StatMarker;
    end else if (sum_d != '0) begin
      status = spd_pkg::StatChecksum;
    end else if (stamp_d > time_limit_i) begin
      status = spd_pkg::StatFuture;
    end else begin
      status = spd_pkg::StatOk;
    end
  end

  always_comb begin
    result_o = '0;
    result_o.status = status;
    if (status == spd_pkg::StatOk) begin
      result_o.sensor_id       = id_d;
      result_o.location        = loc_d;
      result_o.time_stamp      = stamp_d;
      result_o.lux_bits        = lux_d;
      result_o.light_condition = cond_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      sum_q      <= '0;
      start_ok_q <= 1'b0;
      end_ok_q   <= 1'b0;
    end else if (take_i) begin
      if (line_end_i) begin
        pos_q      <= '0;
        sum_q      <= '0;
        start_ok_q <= 1'b0;
        end_ok_q   <= 1'b0;
      end else begin
        pos_q      <= pos_d;
        sum_q      <= sum_d;
        start_ok_q <= start_ok_d;
        end_ok_q   <= end_ok_d;
      end
    end
  end

  // field holds are fully rewritten by every complete frame
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      id_q    <= id_d;
      loc_q   <= loc_d;
      stamp_q <= stamp_d;
      lux_q   <= lux_d;
      cond_q  <= cond_d;
    end
  end

endmodule

// ----- hw/rtl/sensor_packet_deframer.sv -----
// Channel   Role  Word
// in_ch     sink  rx_byte, line_end (one frame byte)
// out_ch    src   status and decoded fields, one per line_end word
// apb       cfg   time_limit at byte address 0
//
// One byte per cycle while in_ch.ready is high; a byte is checked and decoded in the cycle it is taken.
// The result of a line_end byte shows on out_ch the next cycle.
// in_ch.ready drops only while a result is held and out_ch.ready is low.
// rst_ni clears the line state and sets time_limit to all ones.
module sensor_packet_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  spd_in_if.sink                      in_ch,
  spd_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spd_pkg::PaddrW-1:0]  paddr,
  input  logic [spd_pkg::WordW-1:0]   pwdata,
  output logic [spd_pkg::WordW-1:0]   prdata,
  output logic                        pready
);

  logic [spd_pkg::WordW-1:0] time_limit_q;
  logic                      reg_sel;
  logic                      in_take;
  logic                      out_valid_q, out_valid_d;
  spd_pkg::result_t          res;
  spd_pkg::result_t          out_q;

  assign reg_sel = (paddr[2] == spd_pkg::RegTimeLimit);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? time_limit_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_limit_q <= spd_pkg::TimeLimitReset;
    end else if (psel && penable && pwrite && reg_sel) begin
      time_limit_q <= pwdata;
    end
  end

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  spd_frame_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (in_take),
    .rx_byte_i    (in_ch.rx_byte),
    .line_end_i   (in_ch.line_end),
    .time_limit_i (time_limit_q),
    .result_o     (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_take && in_ch.line_end) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && in_ch.line_end) begin
      out_q <= res;
    end
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.status          = out_q.status;
  assign out_ch.sensor_id       = out_q.sensor_id;
  assign out_ch.location        = out_q.location;
  assign out_ch.time_stamp      = out_q.time_stamp;
  assign out_ch.lux_bits        = out_q.lux_bits;
  assign out_ch.light_condition = out_q.light_condition;

  a_line_end_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && in_ch.line_end |=> out_ch.valid)
    else $error("line_end word produced no result");

  a_mid_line_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && !in_ch.line_end && !out_valid_q |=> !out_ch.valid)
    else $error("result without line_end");

  a_error_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.status != spd_pkg::StatOk |->
      out_ch.sensor_id == '0 && out_ch.time_stamp == '0 && out_ch.lux_bits == '0)
    else $error("fields not cleared on error status");

endmodule
